@@ hw/rtl/erq_pkg.sv @@
// Shared types and constants for the event ring queue with reserve.
// Used by erq_mem, erq_seq and the top level; no dependencies.
package erq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned CODE_W          = 16;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned PARAM_W         = 2 * WORD_W;
  localparam int unsigned RESERVE_W       = 5;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 16;

  localparam logic [RESERVE_W-1:0] RESERVE_RST = RESERVE_W'(3);

  localparam logic [CFG_IDX_W-1:0] CFG_PUB_TIMER   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_USER_KEY    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_TIMER = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SYS_TIMER   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE     = CFG_IDX_W'(4);

  typedef enum logic [1:0] {
    OP_PUT        = 2'd0,
    OP_PUT_UNIQUE = 2'd1,
    OP_GET        = 2'd2,
    OP_CLEAR      = 2'd3
  } erq_op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROP    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_EMPTY   = 2'd3
  } erq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_CHK,
    S_PUT,
    S_GET,
    S_CLR,
    S_CLR_CHK,
    S_CLR_END
  } erq_state_t;

  typedef struct packed {
    logic [CODE_W-1:0]    pub_timer;
    logic [CODE_W-1:0]    user_key;
    logic [CODE_W-1:0]    audio_timer;
    logic [CODE_W-1:0]    sys_timer;
    logic [RESERVE_W-1:0] reserve;
  } erq_cfg_t;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [PARAM_W-1:0] param;
  } erq_entry_t;

  typedef struct packed {
    erq_status_t       status;
    logic [CODE_W-1:0] code;
    logic [WORD_W-1:0] param_lo;
    logic [WORD_W-1:0] param_hi;
  } erq_res_t;

endpackage

@@ hw/rtl/erq_mem.sv @@
// Entry store of the event ring: one write port, one read port, registered read.
// Depends on erq_pkg.
module erq_mem #(
  parameter int unsigned QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [PTR_W-1:0]    waddr,
  input  erq_pkg::erq_entry_t wdata,
  input  logic [PTR_W-1:0]    raddr,
  output erq_pkg::erq_entry_t rdata
);
  import erq_pkg::*;

  erq_entry_t mem_r [QUEUE_DEPTH];
  erq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/erq_seq.sv @@
// Sequencer of the event ring: head/tail pointers, scan and drain walks over the
// entry store through one shared code/parameter comparator. Depends on erq_pkg.
module erq_seq #(
  parameter int unsigned QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned PTR_W       = $clog2(QUEUE_DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  erq_pkg::erq_cfg_t             cfg,
  input  logic                          in_accept,
  input  erq_pkg::erq_op_t              op,
  input  logic [erq_pkg::CODE_W-1:0]    event_code,
  input  logic [erq_pkg::PARAM_W-1:0]   param,
  input  logic                          has_param,
  input  logic                          must_hold,
  input  logic [erq_pkg::CODE_W-1:0]    clear_filter,
  output logic                          busy,
  output logic                          done,
  output erq_pkg::erq_res_t             res,
  output logic                          mem_we,
  output logic [PTR_W-1:0]              mem_waddr,
  output erq_pkg::erq_entry_t           mem_wdata,
  output logic [PTR_W-1:0]              mem_raddr,
  input  erq_pkg::erq_entry_t           mem_rdata
);
  import erq_pkg::*;

  localparam int unsigned GAP_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMP_W = (GAP_W > RESERVE_W) ? GAP_W : RESERVE_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  erq_state_t          state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [PTR_W-1:0]    tail_r, tail_nxt;
  logic [PTR_W-1:0]    scan_r, scan_nxt;
  logic                key_seen_r, key_seen_nxt;
  logic [PARAM_W-1:0]  key_param_r, key_param_nxt;
  logic [CODE_W-1:0]   code_r;
  logic [PARAM_W-1:0]  param_r;
  logic                has_param_r;
  logic                hold_r;
  logic [CODE_W-1:0]   filter_r;

  logic                code_hit;
  logic                param_hit;
  logic                is_timer;
  logic                is_key;
  logic                low_prio;
  logic                full;
  logic [GAP_W-1:0]    gap_raw;
  logic [GAP_W-1:0]    gap;
  logic                drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      tail_r     <= '0;
      key_seen_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      key_seen_r <= key_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r      <= scan_nxt;
    key_param_r <= key_param_nxt;
    if (in_accept) begin
      code_r      <= event_code;
      param_r     <= param;
      has_param_r <= has_param;
      hold_r      <= must_hold;
      filter_r    <= clear_filter;
    end
  end

  // shared comparator against the entry just read
  assign code_hit  = (mem_rdata.code == code_r);
  assign param_hit = (mem_rdata.param == param_r);
  assign is_timer  = (mem_rdata.code == cfg.pub_timer) || (mem_rdata.code == cfg.sys_timer);
  assign is_key    = (mem_rdata.code == cfg.user_key);

  assign low_prio = (code_r == cfg.pub_timer) || (code_r == cfg.user_key) ||
                    (code_r == cfg.audio_timer);
  assign full     = (ring_next(tail_r) == head_r);
  assign gap_raw  = (head_r >= tail_r) ? GAP_W'(head_r) - GAP_W'(tail_r)
                                       : GAP_W'(head_r) + GAP_W'(QUEUE_DEPTH) - GAP_W'(tail_r);
  assign gap      = (gap_raw == '0) ? GAP_W'(QUEUE_DEPTH) : gap_raw;
  assign drop     = full || (low_prio && (CMP_W'(gap) <= CMP_W'(cfg.reserve)));

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    scan_nxt      = scan_r;
    key_seen_nxt  = key_seen_r;
    key_param_nxt = key_param_r;
    done          = 1'b0;
    res           = '{status: ST_DONE, code: '0, param_lo: '0, param_hi: '0};
    mem_we        = 1'b0;
    mem_waddr     = tail_r;
    mem_wdata     = '{code: code_r, param: param_r};
    mem_raddr     = head_r;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          scan_nxt     = head_r;
          key_seen_nxt = 1'b0;
          case (op)
            OP_PUT:        state_nxt = S_PUT;
            OP_PUT_UNIQUE: state_nxt = S_SCAN;
            OP_GET:        state_nxt = S_GET;
            OP_CLEAR:      state_nxt = S_CLR;
            default:       state_nxt = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = scan_r;
        state_nxt = (scan_r == tail_r) ? S_PUT : S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (code_hit) begin
          if (!hold_r || (has_param_r && param_hit)) begin
            res.status = ST_PRESENT;
            done       = 1'b1;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_PUT;
          end
        end else begin
          scan_nxt  = ring_next(scan_r);
          state_nxt = S_SCAN;
        end
      end
      S_PUT: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
        if (drop) begin
          res.status = ST_DROP;
        end else begin
          mem_we   = 1'b1;
          tail_nxt = ring_next(tail_r);
        end
      end
      S_GET: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
        if (head_r == tail_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.code     = mem_rdata.code;
          res.param_lo = mem_rdata.param[WORD_W-1:0];
          res.param_hi = mem_rdata.param[PARAM_W-1:WORD_W];
          head_nxt     = ring_next(head_r);
        end
      end
      S_CLR: begin
        state_nxt = (head_r == tail_r) ? S_CLR_END : S_CLR_CHK;
      end
      S_CLR_CHK: begin
        if (is_timer) begin
          if ((filter_r != '0) && (mem_rdata.code != filter_r)) begin
            state_nxt = S_CLR_END;
          end else begin
            head_nxt  = ring_next(head_r);
            state_nxt = S_CLR;
          end
        end else if (is_key) begin
          key_seen_nxt  = 1'b1;
          key_param_nxt = mem_rdata.param;
          head_nxt      = ring_next(head_r);
          state_nxt     = S_CLR;
        end else begin
          state_nxt = S_CLR_END;
        end
      end
      S_CLR_END: begin
        done      = 1'b1;
        state_nxt = S_IDLE;
        if (key_seen_r) begin
          head_nxt  = ring_prev(head_r);
          mem_we    = 1'b1;
          mem_waddr = ring_prev(head_r);
          mem_wdata = '{code: cfg.user_key, param: key_param_r};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_tail_only_on_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_PUT) |=> $stable(tail_r))
    else $error("tail moved outside a put");

  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (done && (res.status == ST_EMPTY)) |-> (head_r == tail_r))
    else $error("empty status with entries queued");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (state_r == S_IDLE))
    else $error("beat accepted while sequencer busy");

endmodule

@@ hw/rtl/event_ring_queue_with_reserve.sv @@
// Event ring queue with reserve: holds up to QUEUE_DEPTH-1 events (code plus two
// parameter words) and runs put, put-unique, get and timer drain, one beat at a
// time. Put-unique and drain walk the queued entries one by one, since every entry
// goes through the single registered read port of the entry store and then the
// shared comparator. One more beat is taken in the cycle after the result beat has
// left the output register. Public-timer, key and audio-timer puts are dropped when
// the gap from tail to head (free slots plus one) is at most the configured reserve.
// The store itself is not cleared at reset.
module event_ring_queue_with_reserve #(
  parameter int unsigned QUEUE_DEPTH = erq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [erq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [erq_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_opcode,
  input  logic [erq_pkg::CODE_W-1:0]       in_event_code,
  input  logic [erq_pkg::WORD_W-1:0]       in_param_lo,
  input  logic [erq_pkg::WORD_W-1:0]       in_param_hi,
  input  logic                             in_has_param,
  input  logic                             in_must_hold,
  input  logic [erq_pkg::CODE_W-1:0]       in_clear_filter,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_status,
  output logic [erq_pkg::CODE_W-1:0]       out_code,
  output logic [erq_pkg::WORD_W-1:0]       out_param_lo,
  output logic [erq_pkg::WORD_W-1:0]       out_param_hi
);
  import erq_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  erq_cfg_t           cfg_r;
  logic               out_valid_r;
  erq_res_t           res_r;
  logic               in_accept;
  logic               busy;
  logic               done;
  erq_res_t           res;
  logic [PARAM_W-1:0] in_param;
  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  erq_entry_t         mem_wdata;
  logic [PTR_W-1:0]   mem_raddr;
  erq_entry_t         mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pub_timer   <= '0;
      cfg_r.user_key    <= '0;
      cfg_r.audio_timer <= '0;
      cfg_r.sys_timer   <= '0;
      cfg_r.reserve     <= RESERVE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PUB_TIMER:   cfg_r.pub_timer   <= cfg_data;
        CFG_USER_KEY:    cfg_r.user_key    <= cfg_data;
        CFG_AUDIO_TIMER: cfg_r.audio_timer <= cfg_data;
        CFG_SYS_TIMER:   cfg_r.sys_timer   <= cfg_data;
        CFG_RESERVE:     cfg_r.reserve     <= cfg_data[RESERVE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall  = busy || out_valid_r;
  assign in_accept = in_valid && !in_stall;
  assign in_param  = in_has_param ? {in_param_hi, in_param_lo} : '0;

  erq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_accept    (in_accept),
    .op           (erq_op_t'(in_opcode)),
    .event_code   (in_event_code),
    .param        (in_param),
    .has_param    (in_has_param),
    .must_hold    (in_must_hold),
    .clear_filter (in_clear_filter),
    .busy         (busy),
    .done         (done),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  erq_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PTR_W       (PTR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = res_r.status;
  assign out_code     = res_r.code;
  assign out_param_lo = res_r.param_lo;
  assign out_param_hi = res_r.param_hi;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_valid_r)
    else $error("result beat overwritten before delivery");

endmodule
